@@ hdl/bad_pkg.sv @@
package bad_pkg;

  localparam int unsigned MaxPrecision   = 16;
  localparam int unsigned MinPrecision   = 2;
  localparam int unsigned WindowBits     = 16;
  localparam int unsigned ResetPrecision = 12;

  localparam int unsigned PrecW  = 5;
  localparam int unsigned ValW   = 16;
  localparam int unsigned CountW = 16;
  localparam int unsigned ProdW  = 32;
  localparam int unsigned DivW   = 17;
  localparam int unsigned StepW  = 4;

  localparam int unsigned TopPrecision =
    (MaxPrecision < WindowBits) ? MaxPrecision : WindowBits;

  localparam logic ReqInit   = 1'b0;
  localparam logic ReqDecode = 1'b1;

  typedef struct packed {
    logic load;
    logic prep;
    logic mul_a;
    logic ld_a;
    logic div_step;
    logic mul_b;
    logic ld_b;
    logic sel;
    logic shift;
    logic emit;
  } bad_cmd_t;

  typedef struct packed {
    logic is_init;
    logic agree;
  } bad_sts_t;

endpackage

@@ hdl/bad_in_if.sv @@
interface bad_in_if import bad_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              req_type;
  logic [ValW-1:0]   bit_window;
  logic              mps_value;
  logic [CountW-1:0] count_mps;
  logic [CountW-1:0] total_count;

  modport source (output valid, req_type, bit_window, mps_value, count_mps, total_count,
                  input ready);
  modport sink (input valid, req_type, bit_window, mps_value, count_mps, total_count,
                output ready);
endinterface

@@ hdl/bad_out_if.sv @@
interface bad_out_if import bad_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             symbol;
  logic [PrecW-1:0] bits_used;

  modport source (output valid, symbol, bits_used, input ready);
  modport sink (input valid, symbol, bits_used, output ready);
endinterface

@@ hdl/bad_datapath.sv @@
module bad_datapath import bad_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  logic [PrecW-1:0]  cfg_wr_data,
  input  logic              req_type,
  input  logic [ValW-1:0]   bit_window,
  input  logic              mps_value,
  input  logic [CountW-1:0] count_mps,
  input  logic [CountW-1:0] total_count,
  input  bad_cmd_t          cmd,
  output bad_sts_t          sts,
  output logic              symbol,
  output logic [PrecW-1:0]  bits_used
);

  function automatic logic [DivW+ProdW-1:0] div_two(
    input logic [DivW-1:0]  r,
    input logic [ProdW-1:0] q,
    input logic [DivW-1:0]  d
  );
    logic [DivW:0]    t;
    logic [DivW-1:0]  rr;
    logic [ProdW-1:0] qq;
    rr = r;
    qq = q;
    for (int i = 0; i < 2; i++) begin
      t = {rr, qq[ProdW-1]};
      if (t >= {1'b0, d}) begin
        rr = DivW'(t - {1'b0, d});
        qq = {qq[ProdW-2:0], 1'b1};
      end else begin
        rr = t[DivW-1:0];
        qq = {qq[ProdW-2:0], 1'b0};
      end
    end
    return {rr, qq};
  endfunction

  logic [PrecW-1:0]  prec;
  logic [ValW-1:0]   lo;
  logic [ValW-1:0]   hi;
  logic [ValW-1:0]   tag;
  logic [PrecW-1:0]  p_r;
  logic [ValW-1:0]   mask_r;
  logic [ValW-1:0]   msb_r;
  logic [ValW-1:0]   win_r;
  logic              mps_r;
  logic [CountW-1:0] cnt_r;
  logic [CountW-1:0] tot_r;
  logic [DivW-1:0]   range_r;
  logic [DivW-1:0]   offs_r;
  logic [ProdW-1:0]  prod;
  logic [DivW-1:0]   rem;
  logic [ProdW-1:0]  quo;
  logic [DivW-1:0]   dvs;
  logic              lt_r;
  logic              sym_r;
  logic [PrecW-1:0]  used_r;

  logic [PrecW-1:0]        p_eff;
  logic [ValW-1:0]         mask_eff;
  logic [DivW+ProdW-1:0]   div_next;

  always_comb begin
    if (prec > PrecW'(TopPrecision)) begin
      p_eff = PrecW'(TopPrecision);
    end else if (prec < PrecW'(MinPrecision)) begin
      p_eff = PrecW'(MinPrecision);
    end else begin
      p_eff = prec;
    end
    mask_eff = ValW'(((ValW+1)'(1) << p_eff) - (ValW+1)'(1));
    div_next = div_two(rem, quo, dvs);
  end

  assign sts.is_init = (req_type == ReqInit);
  assign sts.agree   = (used_r < p_r) && (((lo & msb_r) != '0) == ((hi & msb_r) != '0));

  always_ff @(posedge clk) begin
    if (rst) begin
      prec <= PrecW'(ResetPrecision);
      lo   <= '0;
      hi   <= ValW'((1 << ResetPrecision) - 1);
      tag  <= '0;
    end else begin
      if (cfg_wr_en) begin
        prec <= cfg_wr_data;
      end
      if (cmd.load) begin
        if (req_type == ReqInit) begin
          tag <= bit_window & mask_eff;
          lo  <= '0;
          hi  <= mask_eff;
        end else begin
          tag <= tag & mask_eff;
          lo  <= lo & mask_eff;
          hi  <= hi & mask_eff;
        end
      end
      if (cmd.sel) begin
        if (lt_r) begin
          hi <= (lo + quo[ValW-1:0] - ValW'(1)) & mask_r;
        end else begin
          lo <= (lo + quo[ValW-1:0]) & mask_r;
        end
      end
      if (cmd.shift) begin
        lo  <= (lo << 1) & mask_r;
        hi  <= ((hi << 1) & mask_r) | ValW'(1);
        tag <= ((tag << 1) & mask_r) | ValW'(win_r[ValW-1]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      p_r    <= p_eff;
      mask_r <= mask_eff;
      msb_r  <= mask_eff ^ (mask_eff >> 1);
      win_r  <= bit_window << (PrecW'(WindowBits) - p_eff);
      mps_r  <= mps_value;
      cnt_r  <= count_mps;
      tot_r  <= (total_count == '0) ? CountW'(1) : total_count;
      sym_r  <= 1'b0;
      used_r <= (req_type == ReqInit) ? p_eff : '0;
    end
    if (cmd.prep) begin
      range_r <= {1'b0, (hi - lo) & mask_r} + DivW'(1);
      offs_r  <= {1'b0, (tag - lo) & mask_r} + DivW'(1);
    end
    if (cmd.mul_a) begin
      prod <= ProdW'(33'(offs_r) * 33'(tot_r));
    end
    if (cmd.ld_a) begin
      quo <= prod - ProdW'(1);
      rem <= '0;
      dvs <= range_r;
    end
    if (cmd.div_step) begin
      rem <= div_next[DivW+ProdW-1:ProdW];
      quo <= div_next[ProdW-1:0];
    end
    if (cmd.mul_b) begin
      prod <= ProdW'(33'(range_r) * 33'(cnt_r));
      lt_r <= quo < ProdW'(cnt_r);
    end
    if (cmd.ld_b) begin
      quo <= prod;
      rem <= '0;
      dvs <= {1'b0, tot_r};
    end
    if (cmd.sel) begin
      sym_r <= lt_r ? mps_r : ~mps_r;
    end
    if (cmd.shift) begin
      win_r  <= win_r << 1;
      used_r <= used_r + PrecW'(1);
    end
    if (cmd.emit) begin
      symbol    <= sym_r;
      bits_used <= used_r;
    end
  end

endmodule

@@ hdl/bad_ctrl.sv @@
module bad_ctrl import bad_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  bad_sts_t sts,
  output bad_cmd_t cmd
);

  typedef enum logic [10:0] {
    S_IDLE = 11'b000_0000_0001,
    S_PREP = 11'b000_0000_0010,
    S_MULA = 11'b000_0000_0100,
    S_LDA  = 11'b000_0000_1000,
    S_DIVA = 11'b000_0001_0000,
    S_MULB = 11'b000_0010_0000,
    S_LDB  = 11'b000_0100_0000,
    S_DIVB = 11'b000_1000_0000,
    S_SEL  = 11'b001_0000_0000,
    S_NORM = 11'b010_0000_0000,
    S_DONE = 11'b100_0000_0000
  } state_t;

  state_t           state;
  state_t           state_next;
  logic [StepW-1:0] step;
  logic             step_last;
  logic             out_free;

  assign req_ready = (state == S_IDLE);
  assign step_last = (step == '1);
  assign out_free  = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = sts.is_init ? S_DONE : S_PREP;
        end
      end
      S_PREP: begin
        cmd.prep   = 1'b1;
        state_next = S_MULA;
      end
      S_MULA: begin
        cmd.mul_a  = 1'b1;
        state_next = S_LDA;
      end
      S_LDA: begin
        cmd.ld_a   = 1'b1;
        state_next = S_DIVA;
      end
      S_DIVA: begin
        cmd.div_step = 1'b1;
        if (step_last) begin
          state_next = S_MULB;
        end
      end
      S_MULB: begin
        cmd.mul_b  = 1'b1;
        state_next = S_LDB;
      end
      S_LDB: begin
        cmd.ld_b   = 1'b1;
        state_next = S_DIVB;
      end
      S_DIVB: begin
        cmd.div_step = 1'b1;
        if (step_last) begin
          state_next = S_SEL;
        end
      end
      S_SEL: begin
        cmd.sel    = 1'b1;
        state_next = S_NORM;
      end
      S_NORM: begin
        if (sts.agree) begin
          cmd.shift = 1'b1;
        end else begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.div_step) begin
        step <= step + StepW'(1);
      end else begin
        step <= '0;
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

@@ hdl/binary_arithmetic_decoder.sv @@
// channel  dir  beat fields
// -------  ---  --------------------------------------------------
// req      in   req_type, bit_window, mps_value, count_mps, total_count
// rsp      out  symbol, bits_used
// cfg      in   cfg_wr_en, cfg_wr_data (precision)
//
// One request at a time; req is ready only while the controller idles.
// Init goes from accept straight to the done state. Decode runs two passes
// of the 2-bit-per-cycle divider, then one renormalization shift per bit
// counted in bits_used. The rsp register frees req while a beat waits.
// rst is synchronous; it clears precision to 12 and the interval to full range.
module binary_arithmetic_decoder import bad_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr_en,
  input  logic [PrecW-1:0] cfg_wr_data,
  bad_in_if.sink           req,
  bad_out_if.source        rsp
);

  bad_cmd_t cmd;
  bad_sts_t sts;

  bad_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  bad_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .req_type    (req.req_type),
    .bit_window  (req.bit_window),
    .mps_value   (req.mps_value),
    .count_mps   (req.count_mps),
    .total_count (req.total_count),
    .cmd         (cmd),
    .sts         (sts),
    .symbol      (rsp.symbol),
    .bits_used   (rsp.bits_used)
  );

endmodule

@@ sim/binary_arithmetic_decoder_checker.sv @@
module binary_arithmetic_decoder_checker import bad_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  logic [PrecW-1:0]  cfg_wr_data,
  input  logic              req_valid,
  input  logic              req_ready,
  input  logic              req_type,
  input  logic [ValW-1:0]   bit_window,
  input  logic              mps_value,
  input  logic [CountW-1:0] count_mps,
  input  logic [CountW-1:0] total_count,
  input  logic              rsp_valid,
  input  logic              rsp_ready,
  input  logic              rsp_symbol,
  input  logic [PrecW-1:0]  rsp_bits_used,
  output int unsigned       pending,
  output int unsigned       failures
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic             symbol;
    logic [PrecW-1:0] bits_used;
  } decoded_beat_t;

  logic [PrecW-1:0] precision_reg;
  logic [ValW-1:0]  low_bound;
  logic [ValW-1:0]  high_bound;
  logic [ValW-1:0]  tag_bits;
  decoded_beat_t    awaited_beats[$];
  int unsigned      mismatch_count = 0;

  assign failures = mismatch_count;

  task automatic report_mismatch(input string what);
    if (mismatch_count < 100) $display("%0t ns mismatch: %s", $time, what);
    mismatch_count++;
  endtask

  function automatic decoded_beat_t decode_beat(input logic kind, input logic [ValW-1:0] window,
                                                input logic mps, input logic [CountW-1:0] cnt,
                                                input logic [CountW-1:0] tot_in);
    decoded_beat_t beat;
    int unsigned   p;
    int unsigned   n;
    logic [63:0]   mask, msb, win, lo, hi, tag, tot, span, offset, scaled, part, bit_in;
    p = precision_reg;
    if (p > TopPrecision) p = TopPrecision;
    if (p < MinPrecision) p = MinPrecision;
    mask = (64'd1 << p) - 64'd1;
    msb  = 64'd1 << (p - 1);
    win  = 64'(window);
    if (kind == ReqInit) begin
      tag_bits   = ValW'(win & mask);
      low_bound  = '0;
      high_bound = ValW'(mask);
      beat.symbol    = 1'b0;
      beat.bits_used = PrecW'(p);
      return beat;
    end
    tot = (tot_in == '0) ? 64'd1 : 64'(tot_in);
    lo  = 64'(low_bound) & mask;
    hi  = 64'(high_bound) & mask;
    tag = 64'(tag_bits) & mask;
    span   = ((hi - lo) & mask) + 64'd1;
    offset = ((tag - lo) & mask) + 64'd1;
    scaled = (offset * tot - 64'd1) / span;
    part   = (span * 64'(cnt)) / tot;
    if (scaled < 64'(cnt)) begin
      beat.symbol = mps;
      hi = (lo + part - 64'd1) & mask;
    end else begin
      beat.symbol = ~mps;
      lo = (lo + part) & mask;
    end
    n = 0;
    while (n < p && (((lo & msb) != 0) == ((hi & msb) != 0))) begin
      bit_in = (win >> (p - 1 - n)) & 64'd1;
      lo  = (lo << 1) & mask;
      hi  = ((hi << 1) & mask) + 64'd1;
      tag = ((tag << 1) & mask) + bit_in;
      n++;
    end
    low_bound  = ValW'(lo);
    high_bound = ValW'(hi);
    tag_bits   = ValW'(tag);
    beat.bits_used = PrecW'(n);
    return beat;
  endfunction

  always @(posedge clk) begin : watch
    decoded_beat_t want;
    if (rst) begin
      precision_reg = PrecW'(ResetPrecision);
      low_bound     = '0;
      high_bound    = ValW'((1 << ResetPrecision) - 1);
      tag_bits      = '0;
      awaited_beats.delete();
    end else begin
      if (cfg_wr_en) precision_reg = cfg_wr_data;
      if (rsp_valid && rsp_ready) begin
        if (awaited_beats.size() == 0) begin
          report_mismatch($sformatf("result beat with none awaited: symbol %0b bits_used %0d",
                                    rsp_symbol, rsp_bits_used));
        end else begin
          want = awaited_beats.pop_front();
          if (rsp_symbol !== want.symbol)
            report_mismatch($sformatf("symbol %0b, awaited %0b", rsp_symbol, want.symbol));
          if (rsp_bits_used !== want.bits_used)
            report_mismatch($sformatf("bits_used %0d, awaited %0d",
                                      rsp_bits_used, want.bits_used));
        end
      end
      if (req_valid && req_ready)
        awaited_beats.push_back(decode_beat(req_type, bit_window, mps_value, count_mps,
                                            total_count));
    end
    pending <= awaited_beats.size();
  end

endmodule

@@ sim/binary_arithmetic_decoder_test.sv @@
module binary_arithmetic_decoder_test import bad_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TotalItems = 1050;

  logic             clk;
  logic             rst;
  logic             cfg_wr_en;
  logic [PrecW-1:0] cfg_wr_data;
  int unsigned      pending;
  int unsigned      failures;
  int unsigned      sent = 0;
  logic             tx_calm = 1'b0;

  bad_in_if  req ();
  bad_out_if rsp ();

  binary_arithmetic_decoder dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .req        (req),
    .rsp        (rsp)
  );

  binary_arithmetic_decoder_checker checker_i (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .req_valid    (req.valid),
    .req_ready    (req.ready),
    .req_type     (req.req_type),
    .bit_window   (req.bit_window),
    .mps_value    (req.mps_value),
    .count_mps    (req.count_mps),
    .total_count  (req.total_count),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .rsp_symbol   (rsp.symbol),
    .rsp_bits_used(rsp.bits_used),
    .pending      (pending),
    .failures     (failures)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #(10_000_000);
    $display("binary_arithmetic_decoder test failed");
    $finish;
  end

  // hold off once for a long stretch, run without idling for another
  initial begin
    int unsigned tick;
    tick = 0;
    rsp.ready <= 1'b0;
    forever begin
      @(posedge clk);
      tick++;
      if (tick >= 6000 && tick < 6400) begin
        rsp.ready <= 1'b0;
      end else if (tick >= 20000 && tick < 32000) begin
        rsp.ready <= 1'b1;
      end else begin
        rsp.ready <= ($urandom_range(99) >= 35);
      end
    end
  end

  task automatic send_req(input logic kind, input logic [ValW-1:0] window, input logic mps,
                          input logic [CountW-1:0] cnt, input logic [CountW-1:0] tot);
    while (!tx_calm && $urandom_range(99) < 35) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid       <= 1'b1;
    req.req_type    <= kind;
    req.bit_window  <= window;
    req.mps_value   <= mps;
    req.count_mps   <= cnt;
    req.total_count <= tot;
    do @(posedge clk); while (!req.ready);
    sent++;
  endtask

  task automatic send_init();
    send_req(ReqInit, 16'($urandom), 1'($urandom), 16'($urandom), 16'($urandom));
  endtask

  task automatic wait_results_done();
    do begin
      req.valid <= 1'b0;
      @(posedge clk);
    end while (pending != 0);
  endtask

  task automatic write_precision(input logic [PrecW-1:0] value);
    wait_results_done();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  initial begin
    int unsigned           phase_len;
    int unsigned           pick;
    logic [PrecW-1:0]      prec;
    logic [CountW-1:0]     tot;
    logic [CountW-1:0]     cnt;
    rst             <= 1'b1;
    cfg_wr_en       <= 1'b0;
    cfg_wr_data     <= '0;
    req.valid       <= 1'b0;
    req.req_type    <= ReqInit;
    req.bit_window  <= '0;
    req.mps_value   <= 1'b0;
    req.count_mps   <= '0;
    req.total_count <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    send_req(ReqDecode, 16'hA5A5, 1'b1, 16'd3, 16'd5);
    send_req(ReqInit,   16'hFFFF, 1'b0, 16'd0, 16'd0);
    send_req(ReqDecode, 16'h0000, 1'b0, 16'd1, 16'd65535);
    send_req(ReqDecode, 16'hFFFF, 1'b1, 16'd65534, 16'd65535);
    send_req(ReqDecode, 16'h1234, 1'b1, 16'd0, 16'd10);
    send_req(ReqDecode, 16'h8765, 1'b0, 16'd7, 16'd7);
    send_req(ReqDecode, 16'hFFFF, 1'b1, 16'd65535, 16'd1);
    send_req(ReqDecode, 16'h0F0F, 1'b0, 16'd0, 16'd0);
    send_req(ReqDecode, 16'hF0F0, 1'b1, 16'd1, 16'd0);
    send_req(ReqInit,   16'h0000, 1'b1, 16'hFFFF, 16'hFFFF);
    send_req(ReqDecode, 16'h5555, 1'b1, 16'd1, 16'd2);
    write_precision(5'd16);
    send_req(ReqDecode, 16'hFFFF, 1'b0, 16'd3, 16'd4);
    send_req(ReqInit,   16'h8001, 1'b0, 16'd0, 16'd1);
    send_req(ReqDecode, 16'h0000, 1'b1, 16'd65535, 16'd65535);
    write_precision(5'd0);
    send_req(ReqDecode, 16'hFFFF, 1'b1, 16'd1, 16'd3);
    send_req(ReqInit,   16'h0003, 1'b0, 16'd0, 16'd0);
    send_req(ReqDecode, 16'h0002, 1'b0, 16'd2, 16'd3);
    write_precision(5'd31);
    send_req(ReqInit,   16'hFFFF, 1'b1, 16'd5, 16'd9);
    send_req(ReqDecode, 16'hFFFF, 1'b1, 16'd0, 16'd0);
    write_precision(5'd1);
    send_req(ReqDecode, 16'hAAAA, 1'b0, 16'd1, 16'd2);
    write_precision(5'd2);
    send_req(ReqInit,   16'h0002, 1'b0, 16'd0, 16'd0);
    send_req(ReqDecode, 16'h0001, 1'b1, 16'd1, 16'd65535);
    write_precision(5'd17);
    send_req(ReqDecode, 16'h3C3C, 1'b0, 16'd30000, 16'd60000);
    write_precision(5'd12);
    send_req(ReqInit,   16'h0F0F, 1'b1, 16'd0, 16'd0);
    send_req(ReqDecode, 16'hC3C3, 1'b1, 16'd5, 16'd9);

    while (sent < TotalItems) begin
      case ($urandom_range(9))
        0: prec = 5'd0;
        1: prec = 5'd2;
        2: prec = 5'd16;
        3: prec = 5'($urandom_range(17, 31));
        default: prec = 5'($urandom_range(3, 15));
      endcase
      write_precision(prec);
      if ($urandom_range(3) != 0) send_init();
      phase_len = $urandom_range(40, 120);
      repeat (phase_len) begin
        if (sent >= TotalItems) break;
        tx_calm = (sent >= 400 && sent < 600);
        pick = $urandom_range(99);
        if (pick < 5) begin
          send_init();
        end else if (pick < 85) begin
          tot = ($urandom_range(1) == 0) ? 16'($urandom_range(2, 64))
                                         : 16'($urandom_range(2, 65535));
          case ($urandom_range(5))
            0: cnt = 16'd1;
            1: cnt = tot - 16'd1;
            default: cnt = 16'($urandom_range(1, tot - 1));
          endcase
          send_req(ReqDecode, 16'($urandom), 1'($urandom), cnt, tot);
        end else begin
          case ($urandom_range(3))
            0: tot = '0;
            1: tot = 16'($urandom_range(1, 8));
            default: tot = 16'($urandom);
          endcase
          cnt = ($urandom_range(1) == 0) ? 16'($urandom) : 16'($urandom_range(tot, 65535));
          send_req(ReqDecode, 16'($urandom), 1'($urandom), cnt, tot);
        end
      end
    end
    tx_calm = 1'b0;

    wait_results_done();
    repeat (100) @(posedge clk);
    if (failures == 0) begin
      $display("binary_arithmetic_decoder test passed");
    end else begin
      $display("binary_arithmetic_decoder test failed");
    end
    $finish;
  end

endmodule
